@@ rtl/pcs_pkg.sv @@
package pcs_pkg;

   localparam int SIEVE_DEPTH = 4096;
   localparam int WORD_W      = 32;
   localparam int OFF_W       = $clog2(WORD_W);
   localparam int WORD_COUNT  = SIEVE_DEPTH / WORD_W;
   localparam int ADDR_W      = $clog2(WORD_COUNT);
   localparam int ENTRY_W     = $clog2(SIEVE_DEPTH);
   localparam int SIZE_W      = 13;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int PRIME_W     = 17;
   localparam int MOD_CNT_W   = $clog2(PRIME_W);
   localparam int WALK_W      = PRIME_W + 1;
   localparam int PAT_W       = 2 * WORD_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_MARK  = 2'd1,
      CMD_FETCH = 2'd2
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FOUND     = 2'd1,
      STATUS_EXHAUSTED = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_SUB,
      ST_ALIGN,
      ST_WALK,
      ST_FETCH,
      ST_SCAN,
      ST_OUT_DONE,
      ST_OUT_FOUND,
      ST_OUT_EMPTY
   } state_type;

   typedef struct packed {
      logic clear;
      logic mark_load;
      logic mod_step;
      logic mark_sub;
      logic mark_align;
      logic mark_write;
      logic fetch_first;
      logic fetch_next;
      logic fetch_take;
   } dp_cmd_type;

   typedef struct packed {
      logic prime_zero;
      logic mod_last;
      logic walk_done;
      logic pos_beyond;
      logic fetch_found;
      logic fetch_last;
   } dp_status_type;

   typedef struct packed {
      logic       load;
      status_type status;
   } rsp_cmd_type;

   // Row p holds a one at every multiple of p below PAT_W; row 0 is unused.
   typedef logic [WORD_W-1:0][PAT_W-1:0] pattern_table_type;

   function automatic pattern_table_type build_patterns();
      pattern_table_type t;
      t = '0;
      for (int p = 1; p < WORD_W; p++) begin
         for (int i = 0; i < PAT_W; i += p) begin
            t[p][i] = 1'b1;
         end
      end
      return t;
   endfunction

   localparam pattern_table_type STRIDE_PATTERNS = build_patterns();

endpackage

@@ rtl/pcs_ctrl.sv @@
module pcs_ctrl
   import pcs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [CMD_W-1:0]     req_command,
   input  dp_status_type        dp_status,
   input  logic                 rsp_free,
   output logic                 req_stall,
   output logic                 idle,
   output dp_cmd_type           dp_cmd,
   output rsp_cmd_type          rsp_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      dp_cmd         = '0;
      rsp_cmd.load   = 1'b0;
      rsp_cmd.status = STATUS_DONE;
      req_stall      = (state_ff != ST_IDLE);
      idle           = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (command_type'(req_command))
                  CMD_START: begin
                     dp_cmd.clear = 1'b1;
                     state_in     = ST_OUT_DONE;
                  end
                  CMD_MARK: begin
                     if (dp_status.prime_zero) begin
                        state_in = ST_OUT_DONE;
                     end else begin
                        dp_cmd.mark_load = 1'b1;
                        state_in         = ST_MOD;
                     end
                  end
                  CMD_FETCH: begin
                     state_in = ST_FETCH;
                  end
                  default: begin
                     state_in = ST_OUT_DONE;
                  end
               endcase
            end
         end
         ST_MOD: begin
            dp_cmd.mod_step = 1'b1;
            if (dp_status.mod_last) begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            dp_cmd.mark_sub = 1'b1;
            state_in        = ST_ALIGN;
         end
         ST_ALIGN: begin
            dp_cmd.mark_align = 1'b1;
            state_in          = ST_WALK;
         end
         ST_WALK: begin
            if (dp_status.walk_done) begin
               state_in = ST_OUT_DONE;
            end else begin
               dp_cmd.mark_write = 1'b1;
            end
         end
         ST_FETCH: begin
            if (dp_status.pos_beyond) begin
               state_in = ST_OUT_EMPTY;
            end else begin
               dp_cmd.fetch_first = 1'b1;
               state_in           = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (dp_status.fetch_found) begin
               dp_cmd.fetch_take = 1'b1;
               state_in          = ST_OUT_FOUND;
            end else if (dp_status.fetch_last) begin
               state_in = ST_OUT_EMPTY;
            end else begin
               dp_cmd.fetch_next = 1'b1;
            end
         end
         ST_OUT_DONE: begin
            rsp_cmd.status = STATUS_DONE;
            if (rsp_free) begin
               rsp_cmd.load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_OUT_FOUND: begin
            rsp_cmd.status = STATUS_FOUND;
            if (rsp_free) begin
               rsp_cmd.load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_OUT_EMPTY: begin
            rsp_cmd.status = STATUS_EXHAUSTED;
            if (rsp_free) begin
               rsp_cmd.load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/pcs_datapath.sv @@
module pcs_datapath
   import pcs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [PRIME_W-1:0]   req_prime,
   input  logic [PRIME_W-1:0]   req_residue,
   input  logic [SIZE_W-1:0]    size,
   input  dp_cmd_type           dp_cmd,
   output dp_status_type        dp_status,
   output logic [SIZE_W-1:0]    found_offset
);

   localparam int SHIFT_W = PAT_W + WORD_W - 1;
   localparam int HIGH_W  = SIZE_W - OFF_W;

   function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
      logic [OFF_W-1:0] r;
      r = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (v[b]) begin
            r = OFF_W'(b);
         end
      end
      return r;
   endfunction

   // Ones for the entries of word w that lie below the size in use.
   function automatic logic [WORD_W-1:0] word_limit(input logic [ADDR_W-1:0] w,
                                                    input logic [SIZE_W-1:0] s);
      logic [HIGH_W-1:0] full_words;
      logic [HIGH_W-1:0] w_ext;
      logic [WORD_W-1:0] m;
      full_words = s[SIZE_W-1:OFF_W];
      w_ext      = HIGH_W'(w);
      if (w_ext < full_words) begin
         m = '1;
      end else if (w_ext == full_words) begin
         m = ~({WORD_W{1'b1}} << s[OFF_W-1:0]);
      end else begin
         m = '0;
      end
      return m;
   endfunction

   // Sieve storage, one bit per entry; a row not yet written since the last
   // clear reads as all clear.
   logic [WORD_W-1:0]     sieve_mem [WORD_COUNT];
   logic [WORD_COUNT-1:0] row_valid_ff;
   logic [WORD_COUNT-1:0] row_valid_in;
   logic [WORD_W-1:0]     rd_data_ff;
   logic                  rd_valid_ff;
   logic [ADDR_W-1:0]     rd_addr;

   logic [PRIME_W-1:0]    p_ff,       p_in;
   logic [PRIME_W-1:0]    src_ff,     src_in;
   logic [PRIME_W-1:0]    mod_rem_ff, mod_rem_in;
   logic [MOD_CNT_W-1:0]  mod_cnt_ff, mod_cnt_in;
   logic [WALK_W-1:0]     entry_ff,   entry_in;
   logic [SIZE_W-1:0]     pos_ff,     pos_in;
   logic [ADDR_W-1:0]     scan_word_ff, scan_word_in;
   logic                  first_ff,   first_in;
   logic [SIZE_W-1:0]     offset_ff,  offset_in;

   logic [PRIME_W:0]      mod_trial;
   logic [WALK_W-1:0]     align_sum;
   logic                  p_small;
   logic [ADDR_W-1:0]     wr_addr;
   logic [OFF_W-1:0]      wr_off;
   logic [SHIFT_W-1:0]    stride_shift;
   logic [WORD_W-1:0]     mark_mask;
   logic [ADDR_W:0]       next_wr_word;
   logic [WALK_W-1:0]     walk_next;

   logic [OFF_W-1:0]      scan_lo;
   logic [WORD_W-1:0]     word_marks;
   logic [WORD_W-1:0]     free_bits;
   logic [ENTRY_W-1:0]    found_j;
   logic [HIGH_W-1:0]     next_scan_word;

   // Remainder, one bit of the residue per step.
   assign mod_trial = {mod_rem_ff, src_ff[PRIME_W-1]};

   assign align_sum = entry_ff + WALK_W'(p_ff);

   // Walk: one sieve word per step. Small primes mark every hit in the word
   // from a stride pattern; larger primes hit at most one entry per word.
   assign p_small      = (p_ff[PRIME_W-1:OFF_W] == '0);
   assign wr_addr      = entry_ff[ENTRY_W-1:OFF_W];
   assign wr_off       = entry_ff[OFF_W-1:0];
   assign stride_shift = SHIFT_W'(STRIDE_PATTERNS[p_ff[OFF_W-1:0]]) << wr_off;
   assign mark_mask    = (p_small ? stride_shift[WORD_W-1:0] : (WORD_W'(1) << wr_off))
                         & word_limit(wr_addr, size);
   assign next_wr_word = (ADDR_W+1)'(wr_addr) + 1'b1;
   assign walk_next    = p_small
                         ? WALK_W'({next_wr_word, lowest_set(stride_shift[PAT_W-1:WORD_W])})
                         : align_sum;

   // Fetch: one word per cycle from the scan position onwards.
   assign rd_addr        = dp_cmd.fetch_first ? pos_ff[ENTRY_W-1:OFF_W]
                                              : ADDR_W'(scan_word_ff + 1'b1);
   assign scan_lo        = first_ff ? pos_ff[OFF_W-1:0] : '0;
   assign word_marks     = rd_valid_ff ? rd_data_ff : '0;
   assign free_bits      = ~word_marks & ({WORD_W{1'b1}} << scan_lo)
                           & word_limit(scan_word_ff, size);
   assign found_j        = {scan_word_ff, lowest_set(free_bits)};
   assign next_scan_word = HIGH_W'(scan_word_ff) + 1'b1;

   always_comb begin
      p_in         = p_ff;
      src_in       = src_ff;
      mod_rem_in   = mod_rem_ff;
      mod_cnt_in   = mod_cnt_ff;
      entry_in     = entry_ff;
      pos_in       = pos_ff;
      scan_word_in = scan_word_ff;
      first_in     = first_ff;
      offset_in    = offset_ff;
      row_valid_in = row_valid_ff;

      if (dp_cmd.clear) begin
         pos_in       = '0;
         row_valid_in = '0;
      end
      if (dp_cmd.mark_load) begin
         p_in       = req_prime;
         src_in     = req_residue;
         mod_rem_in = '0;
         mod_cnt_in = MOD_CNT_W'(PRIME_W - 1);
      end
      if (dp_cmd.mod_step) begin
         src_in     = src_ff << 1;
         mod_cnt_in = mod_cnt_ff - 1'b1;
         if (mod_trial >= {1'b0, p_ff}) begin
            mod_rem_in = PRIME_W'(mod_trial - {1'b0, p_ff});
         end else begin
            mod_rem_in = mod_trial[PRIME_W-1:0];
         end
      end
      if (dp_cmd.mark_sub) begin
         entry_in = (mod_rem_ff == '0) ? '0 : WALK_W'(p_ff) - WALK_W'(mod_rem_ff);
      end
      if (dp_cmd.mark_align) begin
         // Only even offsets land on odd candidates; an entry is half of one.
         // With an even prime an odd first offset never becomes even, so the
         // walk starts beyond the sieve and marks nothing.
         entry_in = entry_ff[0] ? (p_ff[0] ? (align_sum >> 1) : '1) : (entry_ff >> 1);
         // From here on p holds the stride in entries.
         p_in     = p_ff[0] ? p_ff : (p_ff >> 1);
      end
      if (dp_cmd.mark_write) begin
         entry_in              = walk_next;
         row_valid_in[wr_addr] = 1'b1;
      end
      if (dp_cmd.fetch_first || dp_cmd.fetch_next) begin
         scan_word_in = rd_addr;
         first_in     = dp_cmd.fetch_first;
      end
      if (dp_cmd.fetch_take) begin
         pos_in    = SIZE_W'(found_j) + 1'b1;
         offset_in = SIZE_W'({found_j, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         pos_ff       <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      src_ff       <= src_in;
      mod_rem_ff   <= mod_rem_in;
      mod_cnt_ff   <= mod_cnt_in;
      entry_ff     <= entry_in;
      scan_word_ff <= scan_word_in;
      first_ff     <= first_in;
      offset_ff    <= offset_in;
   end

   // A row written for the first time since a clear takes the whole mask,
   // so stale bits from an earlier trial never survive.
   always_ff @(posedge clock) begin
      if (dp_cmd.mark_write) begin
         if (!row_valid_ff[wr_addr]) begin
            sieve_mem[wr_addr] <= mark_mask;
         end else begin
            for (int b = 0; b < WORD_W; b++) begin
               if (mark_mask[b]) begin
                  sieve_mem[wr_addr][b] <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff  <= sieve_mem[rd_addr];
      rd_valid_ff <= row_valid_ff[rd_addr];
   end

   assign dp_status.prime_zero  = (req_prime == '0);
   assign dp_status.mod_last    = (mod_cnt_ff == '0);
   assign dp_status.walk_done   = (entry_ff >= WALK_W'(size));
   assign dp_status.pos_beyond  = (pos_ff >= size);
   assign dp_status.fetch_found = (free_bits != '0);
   assign dp_status.fetch_last  = ({next_scan_word, {OFF_W{1'b0}}} >= size);

   assign found_offset = offset_ff;

endmodule

@@ rtl/prime_candidate_sieve_unit.sv @@
// Sieve over the odd candidates n0+2j of one trial value, held as a bitmap
// of 4096 one-bit entries in 128 words of 32 bits, plus a scan position.
// Commands are taken one at a time; each gives exactly one response beat.
// Start clears the sieve and the position (row valid flags are reset, so
// no clearing pass is needed) and then answers. Mark first reduces the
// residue modulo the prime with a bit-serial remainder unit, then walks
// the sieve one word per cycle: a stride below 32 entries (an odd prime
// itself, an even one halved) marks every hit in a word at once, a longer
// stride hits at most one entry per word. A mark therefore walks at most
// min(words in use, hits) steps. Fetch scans from the position one word
// per cycle through the memory's registered read port, and answers
// exhausted without a read when the position already lies at or beyond
// the size in use. A new request beat is taken while the previous
// response still waits to be taken. The entries_in_use register may be
// written only while no command is in flight; values above 4096 act as
// 4096 and 0 means empty.
module prime_candidate_sieve_unit
   import pcs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [PRIME_W-1:0]   req_prime,
   input  logic [PRIME_W-1:0]   req_residue,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SIZE_W-1:0]    rsp_candidate_offset,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [SIZE_W-1:0]    csr_entries_in_use
);

   logic [SIZE_W-1:0]   entries_ff, entries_in;
   logic [SIZE_W-1:0]   size;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SIZE_W-1:0]   rsp_offset_ff, rsp_offset_in;
   logic                rsp_free;
   logic                idle;
   logic [SIZE_W-1:0]   found_offset;
   dp_cmd_type          dp_cmd;
   dp_status_type       dp_status;
   rsp_cmd_type         rsp_cmd;

   assign csr_ready  = idle;
   assign entries_in = (csr_valid && csr_ready) ? csr_entries_in_use : entries_ff;
   assign size       = (entries_ff > SIZE_W'(SIEVE_DEPTH)) ? SIZE_W'(SIEVE_DEPTH)
                                                           : entries_ff;

   // Response register: the next beat may be loaded as the current one leaves.
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in  = rsp_cmd.load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_status_in = rsp_cmd.load ? rsp_cmd.status : rsp_status_ff;
   assign rsp_offset_in = !rsp_cmd.load ? rsp_offset_ff
                        : (rsp_cmd.status == STATUS_FOUND) ? found_offset : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff   <= SIZE_W'(SIEVE_DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         entries_ff   <= entries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_candidate_offset = rsp_offset_ff;

   pcs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .dp_status   (dp_status),
      .rsp_free    (rsp_free),
      .req_stall   (req_stall),
      .idle        (idle),
      .dp_cmd      (dp_cmd),
      .rsp_cmd     (rsp_cmd)
   );

   pcs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_prime    (req_prime),
      .req_residue  (req_residue),
      .size         (size),
      .dp_cmd       (dp_cmd),
      .dp_status    (dp_status),
      .found_offset (found_offset)
   );

endmodule
